[design/pwi_pkg.sv]
package pwi_pkg;

  localparam int NUM_PATCHES = 8;
  localparam int ENTRY_SLOTS = 8;
  localparam int ENTRY_W     = 51;
  localparam int SLOT_W      = $clog2(ENTRY_SLOTS);
  localparam int CFG_DW      = 64;
  localparam int CFG_AW      = SLOT_W + 3;
  localparam int DIV_STEPS   = 32;

  localparam logic [1:0] CODE_ESCAPE  = 2'd0;
  localparam logic [1:0] CODE_STICK   = 2'd1;
  localparam logic [1:0] CODE_REBOUND = 2'd2;

  localparam logic [1:0] ST_OK          = 2'd0;
  localparam logic [1:0] ST_NO_MATCH    = 2'd1;
  localparam logic [1:0] ST_BAD_CODE    = 2'd2;
  localparam logic [1:0] ST_ZERO_NORMAL = 2'd3;

  localparam logic [1:0] VM_PASS = 2'd0;
  localparam logic [1:0] VM_ZERO = 2'd1;
  localparam logic [1:0] VM_CALC = 2'd2;

  typedef struct packed {
    logic [1:0]       status;
    logic             keep;
    logic [1:0]       vmode;
    logic [2:0][31:0] u;
    logic [2:0]       nneg;
    logic             dneg;
    logic             inward;
    logic [15:0]      e;
    logic [15:0]      mu;
  } pwi_ctl_t;

endpackage

[design/pwi_ifs.sv]
interface pwi_in_if;
  logic               valid;
  logic               ready;
  logic [15:0]        patch_id;
  logic signed [31:0] normal_x;
  logic signed [31:0] normal_y;
  logic signed [31:0] normal_z;
  logic signed [31:0] vel_in_x;
  logic signed [31:0] vel_in_y;
  logic signed [31:0] vel_in_z;

  modport source (output valid, patch_id, normal_x, normal_y, normal_z,
                  vel_in_x, vel_in_y, vel_in_z, input ready);
  modport sink (input valid, patch_id, normal_x, normal_y, normal_z,
                vel_in_x, vel_in_y, vel_in_z, output ready);
endinterface

interface pwi_out_if;
  logic               valid;
  logic               ready;
  logic [1:0]         status;
  logic               keep_particle;
  logic signed [31:0] vel_out_x;
  logic signed [31:0] vel_out_y;
  logic signed [31:0] vel_out_z;

  modport source (output valid, status, keep_particle, vel_out_x, vel_out_y,
                  vel_out_z, input ready);
  modport sink (input valid, status, keep_particle, vel_out_x, vel_out_y,
                vel_out_z, output ready);
endinterface

[design/particle_wall_interaction.sv]
// Throughput: one item per cycle while the output does not stall; the
// 32 stages of the pipelined divider that forms the normal part of the
// velocity set the depth. A stalled output holds its stage, and bubbles
// ahead of it still fill. Reset clears all stage valid bits and all
// patch entries.
module particle_wall_interaction (
  input  logic                       clk,
  input  logic                       rst_n,
  pwi_in_if.sink                     in_ch,
  pwi_out_if.source                  out_ch,
  input  logic                       cfg_psel,
  input  logic                       cfg_penable,
  input  logic                       cfg_pwrite,
  input  logic [pwi_pkg::CFG_AW-1:0] cfg_paddr,
  input  logic [pwi_pkg::CFG_DW-1:0] cfg_pwdata,
  output logic [pwi_pkg::CFG_DW-1:0] cfg_prdata,
  output logic                       cfg_pready
);
  import pwi_pkg::*;

  localparam int S_IN   = 0;
  localparam int S_LKP  = 1;
  localparam int S_SUM  = 2;
  localparam int S_ABS  = 3;
  localparam int S_PP   = 4;
  localparam int S_NUM  = 5;
  localparam int S_DIV0 = 6;
  localparam int S_PT   = S_DIV0 + DIV_STEPS;
  localparam int S_PRD  = S_PT + 1;
  localparam int S_ACC  = S_PRD + 1;
  localparam int S_OUT  = S_ACC + 1;
  localparam int NST    = S_OUT + 1;

  localparam logic signed [52:0] SAT_MAX = 53'sd2147483647;
  localparam logic signed [52:0] SAT_MIN = -53'sd2147483648;

  logic [ENTRY_W-1:0] entry_r [ENTRY_SLOTS];
  logic [NST-1:0]     valid_r;
  logic [NST-1:0]     adv;

  // Configuration port.
  logic [SLOT_W-1:0] cfg_idx;
  assign cfg_idx    = cfg_paddr[CFG_AW-1:3];
  assign cfg_pready = 1'b1;
  assign cfg_prdata = CFG_DW'(entry_r[cfg_idx]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < ENTRY_SLOTS; i++) entry_r[i] <= '0;
    end else if (cfg_psel && cfg_penable && cfg_pwrite) begin
      entry_r[cfg_idx] <= cfg_pwdata[ENTRY_W-1:0];
    end
  end

  // Stage handshake: a stage loads when it is empty or its successor loads.
  assign adv[NST-1] = !valid_r[NST-1] || out_ch.ready;
  for (genvar g = 0; g < NST-1; g++) begin : g_adv
    assign adv[g] = !valid_r[g] || adv[g+1];
  end
  assign in_ch.ready = adv[S_IN];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      if (adv[S_IN]) valid_r[S_IN] <= in_ch.valid;
      for (int i = 1; i < NST; i++) begin
        if (adv[i]) valid_r[i] <= valid_r[i-1];
      end
    end
  end

  // Input register.
  logic [15:0]        in_id_r;
  logic signed [31:0] in_n_r [3];
  logic signed [31:0] in_u_r [3];

  always_ff @(posedge clk) begin
    if (adv[S_IN]) begin
      in_id_r   <= in_ch.patch_id;
      in_n_r[0] <= in_ch.normal_x;
      in_n_r[1] <= in_ch.normal_y;
      in_n_r[2] <= in_ch.normal_z;
      in_u_r[0] <= in_ch.vel_in_x;
      in_u_r[1] <= in_ch.vel_in_y;
      in_u_r[2] <= in_ch.vel_in_z;
    end
  end

  pwi_ctl_t ctl_r [1:S_ACC];

  // Patch lookup and the products of the two dot products.
  logic               lk_hit;
  logic [SLOT_W-1:0]  lk_idx;
  logic [ENTRY_W-1:0] lk_ent;
  pwi_ctl_t           lk_ctl;
  logic [31:0]        lk_nm [3];
  logic signed [63:0] lk_nn_r [3];
  logic signed [63:0] lk_dn_r [3];
  logic [31:0]        lk_nm_r [3];

  always_comb begin
    lk_hit = 1'b0;
    lk_idx = '0;
    for (int i = 0; i < NUM_PATCHES; i++) begin
      if (!lk_hit && entry_r[i][18] && entry_r[i][15:0] == in_id_r) begin
        lk_hit = 1'b1;
        lk_idx = SLOT_W'(i);
      end
    end
    lk_ent = entry_r[lk_idx];
    lk_ctl.u[0]   = in_u_r[0];
    lk_ctl.u[1]   = in_u_r[1];
    lk_ctl.u[2]   = in_u_r[2];
    lk_ctl.nneg   = {in_n_r[2][31], in_n_r[1][31], in_n_r[0][31]};
    lk_ctl.dneg   = 1'b0;
    lk_ctl.inward = 1'b0;
    lk_ctl.e      = lk_ent[34:19];
    lk_ctl.mu     = lk_ent[50:35];
    lk_ctl.status = ST_OK;
    lk_ctl.keep   = 1'b1;
    lk_ctl.vmode  = VM_PASS;
    if (!lk_hit) begin
      lk_ctl.status = ST_NO_MATCH;
    end else begin
      case (lk_ent[17:16])
        CODE_ESCAPE: begin
          lk_ctl.keep  = 1'b0;
          lk_ctl.vmode = VM_ZERO;
        end
        CODE_STICK: begin
          lk_ctl.vmode = VM_ZERO;
        end
        CODE_REBOUND: begin
          lk_ctl.vmode = VM_CALC;
        end
        default: begin
          lk_ctl.status = ST_BAD_CODE;
        end
      endcase
    end
    for (int k = 0; k < 3; k++) begin
      lk_nm[k] = in_n_r[k][31] ? 32'(-in_n_r[k]) : in_n_r[k];
    end
  end

  always_ff @(posedge clk) begin
    if (adv[S_LKP]) begin
      ctl_r[S_LKP] <= lk_ctl;
      for (int k = 0; k < 3; k++) begin
        lk_nn_r[k] <= in_n_r[k] * in_n_r[k];
        lk_dn_r[k] <= in_u_r[k] * in_n_r[k];
        lk_nm_r[k] <= lk_nm[k];
      end
    end
  end

  // Sums: Q = n.n and D = v.n.
  logic [63:0]        sm_q_r;
  logic signed [65:0] sm_d_r;
  logic [31:0]        sm_nm_r [3];

  always_ff @(posedge clk) begin
    if (adv[S_SUM]) begin
      sm_q_r  <= 64'(lk_nn_r[0]) + 64'(lk_nn_r[1]) + 64'(lk_nn_r[2]);
      sm_d_r  <= 66'(lk_dn_r[0]) + 66'(lk_dn_r[1]) + 66'(lk_dn_r[2]);
      sm_nm_r <= lk_nm_r;
    end
  end

  // Magnitude of D and the zero normal check.
  logic [63:0] ab_q_r;
  logic [63:0] ab_dmag_r;
  logic [31:0] ab_nm_r [3];
  logic [63:0] ab_dmag;
  pwi_ctl_t    ab_ctl;

  always_comb begin
    ab_dmag = sm_d_r[65] ? 64'(-sm_d_r) : 64'(sm_d_r);
    ab_ctl        = ctl_r[S_SUM];
    ab_ctl.dneg   = sm_d_r[65];
    ab_ctl.inward = !sm_d_r[65] && (ab_dmag != 64'd0);
    if (ctl_r[S_SUM].vmode == VM_CALC && sm_q_r == 64'd0) begin
      ab_ctl.status = ST_ZERO_NORMAL;
      ab_ctl.vmode  = VM_PASS;
    end
  end

  always_ff @(posedge clk) begin
    if (adv[S_ABS]) begin
      ctl_r[S_ABS] <= ab_ctl;
      ab_q_r       <= sm_q_r;
      ab_dmag_r    <= ab_dmag;
      ab_nm_r      <= sm_nm_r;
    end
  end

  // Partial products of |D| * |n_k|.
  logic [63:0] pp_q_r;
  logic [63:0] pp_lo_r [3];
  logic [63:0] pp_hi_r [3];

  always_ff @(posedge clk) begin
    if (adv[S_PP]) begin
      pp_q_r <= ab_q_r;
      for (int k = 0; k < 3; k++) begin
        pp_lo_r[k] <= ab_dmag_r[31:0] * ab_nm_r[k];
        pp_hi_r[k] <= ab_dmag_r[63:32] * ab_nm_r[k];
      end
    end
  end

  // Dividend assembly, then one quotient bit per stage.
  logic [2:0][63:0] dv_rem_r [DIV_STEPS];
  logic [2:0][31:0] dv_lo_r  [DIV_STEPS+1];
  logic [63:0]      dv_q_r   [DIV_STEPS];
  logic [95:0]      nu_num [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      nu_num[k] = {32'd0, pp_lo_r[k]} + {pp_hi_r[k], 32'd0};
    end
  end

  always_ff @(posedge clk) begin
    if (adv[S_NUM]) begin
      dv_q_r[0] <= pp_q_r;
      for (int k = 0; k < 3; k++) begin
        dv_rem_r[0][k] <= nu_num[k][95:32];
        dv_lo_r[0][k]  <= nu_num[k][31:0];
      end
    end
  end

  for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
    logic [2:0][64:0] r2;
    logic [2:0]       ge;

    always_comb begin
      for (int k = 0; k < 3; k++) begin
        r2[k] = {dv_rem_r[j][k], dv_lo_r[j][k][31]};
        ge[k] = r2[k] >= {1'b0, dv_q_r[j]};
      end
    end

    always_ff @(posedge clk) begin
      if (adv[S_DIV0+j]) begin
        for (int k = 0; k < 3; k++) begin
          dv_lo_r[j+1][k] <= {dv_lo_r[j][k][30:0], ge[k]};
        end
      end
    end

    if (j < DIV_STEPS-1) begin : g_carry
      always_ff @(posedge clk) begin
        if (adv[S_DIV0+j]) begin
          dv_q_r[j+1] <= dv_q_r[j];
          for (int k = 0; k < 3; k++) begin
            dv_rem_r[j+1][k] <= ge[k] ? 64'(r2[k] - {1'b0, dv_q_r[j]}) : r2[k][63:0];
          end
        end
      end
    end
  end

  // Control travels unchanged through the stages that do not touch it.
  for (genvar g = S_PP; g <= S_ACC; g++) begin : g_ctl
    always_ff @(posedge clk) begin
      if (adv[g]) ctl_r[g] <= ctl_r[g-1];
    end
  end
  always_ff @(posedge clk) begin
    if (adv[S_SUM]) ctl_r[S_SUM] <= ctl_r[S_LKP];
  end

  // Signed normal part p and tangential part t.
  logic signed [32:0] pt_p_r [3];
  logic signed [34:0] pt_t_r [3];
  logic signed [32:0] pt_p [3];
  logic signed [31:0] pt_u [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      pt_u[k] = ctl_r[S_PT-1].u[k];
      if (ctl_r[S_PT-1].dneg != ctl_r[S_PT-1].nneg[k]) begin
        pt_p[k] = -$signed({1'b0, dv_lo_r[DIV_STEPS][k]});
      end else begin
        pt_p[k] = $signed({1'b0, dv_lo_r[DIV_STEPS][k]});
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv[S_PT]) begin
      for (int k = 0; k < 3; k++) begin
        pt_p_r[k] <= pt_p[k];
        pt_t_r[k] <= 35'(pt_u[k]) - 35'(pt_p[k]);
      end
    end
  end

  // Loss products.
  logic signed [51:0] pr_mt_r [3];
  logic signed [50:0] pr_ep_r [3];
  logic [16:0]        pr_ef;

  assign pr_ef = 17'd32768 + {1'b0, ctl_r[S_PT].e};

  always_ff @(posedge clk) begin
    if (adv[S_PRD]) begin
      for (int k = 0; k < 3; k++) begin
        pr_mt_r[k] <= $signed({1'b0, ctl_r[S_PT].mu}) * pt_t_r[k];
        if (ctl_r[S_PT].inward) begin
          pr_ep_r[k] <= $signed({1'b0, pr_ef}) * pt_p_r[k];
        end else begin
          pr_ep_r[k] <= '0;
        end
      end
    end
  end

  // Accumulation.
  logic signed [52:0] ac_acc_r [3];
  logic signed [52:0] ac_us [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      ac_us[k] = {{6{ctl_r[S_PRD].u[k][31]}}, ctl_r[S_PRD].u[k], 15'd0};
    end
  end

  always_ff @(posedge clk) begin
    if (adv[S_ACC]) begin
      for (int k = 0; k < 3; k++) begin
        ac_acc_r[k] <= ac_us[k] - 53'(pr_mt_r[k]) - 53'(pr_ep_r[k]);
      end
    end
  end

  // Rounding, saturation and result selection into the output register.
  logic signed [52:0] ro_sh [3];
  logic [31:0]        ro_vel [3];
  logic [1:0]         out_status_r;
  logic               out_keep_r;
  logic [31:0]        out_vel_r [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      ro_sh[k] = (ac_acc_r[k] + 53'sd16384) >>> 15;
      case (ctl_r[S_ACC].vmode)
        VM_ZERO: ro_vel[k] = '0;
        VM_CALC: begin
          if (ro_sh[k] > SAT_MAX) begin
            ro_vel[k] = SAT_MAX[31:0];
          end else if (ro_sh[k] < SAT_MIN) begin
            ro_vel[k] = SAT_MIN[31:0];
          end else begin
            ro_vel[k] = ro_sh[k][31:0];
          end
        end
        default: ro_vel[k] = ctl_r[S_ACC].u[k];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (adv[S_OUT]) begin
      out_status_r <= ctl_r[S_ACC].status;
      out_keep_r   <= ctl_r[S_ACC].keep;
      out_vel_r    <= ro_vel;
    end
  end

  assign out_ch.valid         = valid_r[S_OUT];
  assign out_ch.status        = out_status_r;
  assign out_ch.keep_particle = out_keep_r;
  assign out_ch.vel_out_x     = out_vel_r[0];
  assign out_ch.vel_out_y     = out_vel_r[1];
  assign out_ch.vel_out_z     = out_vel_r[2];

endmodule

[dv/tb_particle_wall_interaction.sv]
`timescale 1ns / 100ps

module tb_particle_wall_interaction;
  import pwi_pkg::*;

  localparam logic [1:0] CODE_INVALID = 2'd3;
  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 60;

  typedef logic bool_t;

  typedef struct {
    logic [15:0]        id;
    logic signed [31:0] nrm [3];
    logic signed [31:0] vel [3];
  } wall_hit_t;

  typedef struct {
    logic [1:0]         status;
    logic               keep;
    logic signed [31:0] vel [3];
  } rebound_t;

  class rebound_scoreboard;
    logic [ENTRY_W-1:0] entries [ENTRY_SLOTS];
    rebound_t           expected_q [$];
    int                 mismatches;
    int                 hits_seen;
    int                 results_seen;

    function new();
      foreach (entries[i]) entries[i] = '0;
      mismatches = 0;
      hits_seen = 0;
      results_seen = 0;
    endfunction

    function void set_entry(int slot, logic [63:0] value);
      entries[slot] = value[ENTRY_W-1:0];
    endfunction

    function rebound_t predict(wall_hit_t h);
      rebound_t r;
      int found;
      logic [ENTRY_W-1:0] ent;
      logic [1:0] code;
      logic signed [127:0] nv [3];
      logic signed [127:0] uv [3];
      logic signed [127:0] dot_un, acc, p, y, e, mu;
      logic [127:0] nn, dmag, nm, q;
      logic dneg, inward;
      r.status = ST_NO_MATCH;
      r.keep = 1'b1;
      for (int k = 0; k < 3; k++) r.vel[k] = h.vel[k];
      found = -1;
      for (int i = 0; i < NUM_PATCHES; i++) begin
        if (found < 0 && entries[i][18] && entries[i][15:0] == h.id) found = i;
      end
      if (found < 0) return r;
      ent = entries[found];
      code = ent[17:16];
      if (code == CODE_ESCAPE || code == CODE_STICK) begin
        r.status = ST_OK;
        r.keep = (code == CODE_STICK);
        for (int k = 0; k < 3; k++) r.vel[k] = '0;
        return r;
      end
      if (code == CODE_INVALID) begin
        r.status = ST_BAD_CODE;
        return r;
      end
      nn = '0;
      dot_un = '0;
      for (int k = 0; k < 3; k++) begin
        nv[k] = h.nrm[k];
        uv[k] = h.vel[k];
        nn = nn + nv[k] * nv[k];
        dot_un = dot_un + uv[k] * nv[k];
      end
      if (nn == 0) begin
        r.status = ST_ZERO_NORMAL;
        return r;
      end
      e = {112'd0, ent[34:19]};
      mu = {112'd0, ent[50:35]};
      dneg = dot_un < 0;
      dmag = dneg ? -dot_un : dot_un;
      inward = !dneg && dmag != 0;
      r.status = ST_OK;
      r.keep = 1'b1;
      for (int k = 0; k < 3; k++) begin
        nm = (nv[k] < 0) ? -nv[k] : nv[k];
        q = (dmag * nm) / nn;
        p = q;
        if (dneg != (nv[k] < 0)) p = -p;
        acc = uv[k] * 32768 - mu * (uv[k] - p);
        if (inward) acc = acc - (32768 + e) * p;
        y = (acc + 16384) >>> 15;
        if (y > 128'sd2147483647) y = 128'sd2147483647;
        if (y < -128'sd2147483648) y = -128'sd2147483648;
        r.vel[k] = y[31:0];
      end
      return r;
    endfunction

    function void note_hit(wall_hit_t h);
      expected_q.push_back(predict(h));
      hits_seen++;
    endfunction

    function void check_result(rebound_t got);
      rebound_t exp_r;
      bool_t bad;
      results_seen++;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result transfer: status %0d", got.status);
        return;
      end
      exp_r = expected_q.pop_front();
      bad = got.status !== exp_r.status || got.keep !== exp_r.keep;
      for (int k = 0; k < 3; k++) if (got.vel[k] !== exp_r.vel[k]) bad = 1'b1;
      if (bad) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result %0d: expected st=%0d keep=%0d v=%h %h %h, got st=%0d keep=%0d v=%h %h %h",
                   results_seen, exp_r.status, exp_r.keep, exp_r.vel[0], exp_r.vel[1],
                   exp_r.vel[2], got.status, got.keep, got.vel[0], got.vel[1], got.vel[2]);
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic cfg_psel, cfg_penable, cfg_pwrite;
  logic [CFG_AW-1:0] cfg_paddr;
  logic [CFG_DW-1:0] cfg_pwdata, cfg_prdata;
  logic cfg_pready;

  pwi_in_if in_if ();
  pwi_out_if out_if ();

  particle_wall_interaction dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_if.sink), .out_ch(out_if.source),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  rebound_scoreboard sb = new();
  int cycle_count = 0;
  int burst_left = 0;
  int stall_count = 0;
  logic [15:0] live_ids [ENTRY_SLOTS];

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  always @(posedge clk) begin
    stall_count <= stall_count + 1;
    case (stall_count[9:8])
      2'd0: out_if.ready <= 1'b1;
      2'd1: out_if.ready <= ($urandom_range(0, 3) != 0);
      2'd2: out_if.ready <= (stall_count[2:0] != 3'd0);
      default: out_if.ready <= ($urandom_range(0, 1) == 1);
    endcase
  end

  always @(posedge clk) begin
    rebound_t got;
    if (rst_n && out_if.valid && out_if.ready) begin
      got.status = out_if.status;
      got.keep = out_if.keep_particle;
      got.vel[0] = out_if.vel_out_x;
      got.vel[1] = out_if.vel_out_y;
      got.vel[2] = out_if.vel_out_z;
      sb.check_result(got);
    end
  end

  function automatic logic [63:0] pack_entry(logic [15:0] id, logic [1:0] code, logic ok,
                                             logic [15:0] e, logic [15:0] mu);
    return {13'd0, mu, e, ok, code, id};
  endfunction

  function automatic logic signed [31:0] pick_value();
    case ($urandom_range(0, 9))
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      2: return 32'sd0;
      3, 4, 5: return $urandom;
      default: return $signed($urandom_range(0, 32'h3ffff)) - 32'sh1ffff;
    endcase
  endfunction

  task automatic write_entry(int slot, logic [63:0] value);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= CFG_AW'(slot * 8);
    cfg_pwdata <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    sb.set_entry(slot, value);
    live_ids[slot] = value[15:0];
    @(posedge clk);
  endtask

  task automatic send_hit(wall_hit_t h);
    if (burst_left == 0) begin
      if ($urandom_range(0, 2) != 0) begin
        in_if.valid <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    in_if.patch_id <= h.id;
    in_if.normal_x <= h.nrm[0];
    in_if.normal_y <= h.nrm[1];
    in_if.normal_z <= h.nrm[2];
    in_if.vel_in_x <= h.vel[0];
    in_if.vel_in_y <= h.vel[1];
    in_if.vel_in_z <= h.vel[2];
    in_if.valid <= 1'b1;
    do @(posedge clk); while (!in_if.ready);
    sb.note_hit(h);
    burst_left--;
  endtask

  task automatic send_vec(logic [15:0] id, logic signed [31:0] nx, logic signed [31:0] ny,
                          logic signed [31:0] nz, logic signed [31:0] vx,
                          logic signed [31:0] vy, logic signed [31:0] vz);
    wall_hit_t h;
    h.id = id;
    h.nrm[0] = nx; h.nrm[1] = ny; h.nrm[2] = nz;
    h.vel[0] = vx; h.vel[1] = vy; h.vel[2] = vz;
    send_hit(h);
  endtask

  task automatic settle();
    in_if.valid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic random_table();
    logic [15:0] pool [4];
    logic [15:0] e, mu;
    logic [1:0] code;
    foreach (pool[i]) pool[i] = $urandom;
    for (int s = 0; s < ENTRY_SLOTS; s++) begin
      code = ($urandom_range(0, 2) == 0) ? 2'($urandom_range(0, 3)) : CODE_REBOUND;
      e = ($urandom_range(0, 3) == 0) ? (($urandom_range(0, 1) == 1) ? 16'hffff : 16'h0)
                                       : 16'($urandom);
      mu = ($urandom_range(0, 3) == 0) ? (($urandom_range(0, 1) == 1) ? 16'hffff : 16'h0)
                                        : 16'($urandom);
      write_entry(s, pack_entry(($urandom_range(0, 1) == 1) ? pool[$urandom_range(0, 3)]
                                                           : 16'($urandom),
                                code, $urandom_range(0, 6) != 0, e, mu));
    end
  endtask

  task automatic random_hits(int count);
    wall_hit_t h;
    for (int i = 0; i < count; i++) begin
      h.id = ($urandom_range(0, 6) != 0) ? live_ids[$urandom_range(0, ENTRY_SLOTS - 1)]
                                         : 16'($urandom);
      for (int k = 0; k < 3; k++) begin
        h.nrm[k] = pick_value();
        h.vel[k] = pick_value();
      end
      if ($urandom_range(0, 19) == 0) foreach (h.nrm[k]) h.nrm[k] = '0;
      send_hit(h);
    end
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    cfg_paddr = '0;
    cfg_pwdata = '0;
    in_if.valid = 1'b0;
    in_if.patch_id = '0;
    in_if.normal_x = '0;
    in_if.normal_y = '0;
    in_if.normal_z = '0;
    in_if.vel_in_x = '0;
    in_if.vel_in_y = '0;
    in_if.vel_in_z = '0;
    out_if.ready = 1'b0;
    foreach (live_ids[i]) live_ids[i] = '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_vec(16'h0000, 32'sh10000, 0, 0, 32'sh10000, 0, 0);
    settle();
    write_entry(0, pack_entry(16'h0000, CODE_ESCAPE, 1'b1, 16'h0, 16'h0));
    write_entry(1, pack_entry(16'hffff, CODE_STICK, 1'b1, 16'h0, 16'h0));
    write_entry(2, pack_entry(16'h1234, CODE_REBOUND, 1'b1, 16'h0, 16'h0));
    write_entry(3, pack_entry(16'h2345, CODE_REBOUND, 1'b1, 16'hffff, 16'hffff));
    write_entry(4, pack_entry(16'h3456, CODE_INVALID, 1'b1, 16'h8000, 16'h8000));
    write_entry(5, pack_entry(16'h1234, CODE_REBOUND, 1'b1, 16'h8000, 16'h4000));
    write_entry(6, pack_entry(16'h4567, CODE_REBOUND, 1'b0, 16'h8000, 16'h4000));
    write_entry(7, pack_entry(16'h5678, CODE_REBOUND, 1'b1, 16'h6000, 16'h1000));
    send_vec(16'h0000, 32'sh10000, 0, 0, 32'sh7fffffff, -1, 5);
    send_vec(16'hffff, 32'sh80000000, 0, 0, 32'sh80000000, 3, -3);
    send_vec(16'h1234, 32'sh10000, 0, 0, 32'sh20000, 32'sh10000, 0);
    send_vec(16'h1234, 0, 0, 0, 32'sh20000, 1, 2);
    send_vec(16'h2345, 32'sh10000, 32'sh10000, 0, 32'sh7fffffff, 32'sh7fffffff, 0);
    send_vec(16'h2345, 32'sh80000000, 0, 0, 32'sh80000000, 32'sh7fffffff, 32'sh80000000);
    send_vec(16'h2345, 32'sh10000, 0, 0, -32'sh30000, 32'sh10000, 0);
    send_vec(16'h3456, 32'sh10000, 0, 0, 32'sh1234, 1, 2);
    send_vec(16'h4567, 32'sh10000, 0, 0, 32'sh1234, 1, 2);
    send_vec(16'h9999, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, -1, -1, -1);
    send_vec(16'h5678, 3, -7, 11, 32'sh12345, -32'sh54321, 32'sh777);
    send_vec(16'h5678, 32'sh7fffffff, 32'sh80000000, 32'sh7fffffff,
             32'sh80000000, 32'sh7fffffff, 32'sh80000000);
    send_vec(16'h5678, 0, 0, 1, 0, 0, 0);
    settle();

    for (int phase = 0; phase < 5; phase++) begin
      random_table();
      random_hits(120);
      settle();
    end
    for (int s = 0; s < ENTRY_SLOTS; s++)
      write_entry(s, pack_entry(16'(s), CODE_REBOUND, 1'b1, 16'hffff, 16'hffff));
    random_hits(30);
    settle();

    $display("Covered %0d wall hits over seven patch tables, %0d results compared.",
             sb.hits_seen, sb.results_seen);
    if (sb.mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("%0d mismatching results.", sb.mismatches);
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
